// File: src/bsa_pkg.sv
// Shared types, codes and helper functions of the bucket slot allocator.
`default_nettype none

package bsa_pkg;

   localparam int SLOT_W   = 6;
   localparam int SLOTS    = 64;
   localparam int BUCKET_W = 6;

   typedef logic [SLOTS-1:0]  mask_type;
   typedef logic [SLOT_W-1:0] slot_type;

   localparam mask_type FULL_MASK = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam mask_type MASK_ONE  = 64'h0000_0000_0000_0001;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_DONE = 1'b0,
      STATUS_FAIL = 1'b1
   } status_type;

   // Encode a one-hot (or zero) mask into the index of its set bit.
   function automatic slot_type onehot_index(input mask_type onehot);
      slot_type idx;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (onehot[i]) begin
            idx = idx | slot_type'(i);
         end
      end
      return idx;
   endfunction

   // Isolate the lowest clear bit of a mask as a one-hot word.
   function automatic mask_type lowest_clear(input mask_type mask);
      mask_type inv;
      inv = ~mask;
      return inv & (~inv + MASK_ONE);
   endfunction

endpackage

`default_nettype wire

// File: src/bucket_slot_allocator.sv
// Top level of the bucket slot allocator: state machine, mask and stack memories.
// Steps: a free, a fresh-bucket allocate or a failed allocate goes from ST_IDLE to ST_UPDATE,
//   which loads the result register; a pop from the open-bucket stack passes through ST_POP
//   first, as the stack read must return before the bucket's mask can be read.
// No new transaction is taken until ST_UPDATE loads its result (one read-modify-write
//   pass); a result waiting on rsp_ready holds the update step and so the next acceptance.
// Reset clears the state, the stack depth, the opened-bucket count and the result valid flag only.
`default_nettype none

module bucket_slot_allocator
   import bsa_pkg::*;
#(
   parameter int BUCKETS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_func,
   input  wire logic [BUCKET_W-1:0] req_free_bucket,
   input  wire logic [SLOT_W-1:0]   req_free_slot,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_status,
   output logic [BUCKET_W-1:0]      rsp_given_bucket,
   output logic [SLOT_W-1:0]        rsp_given_slot
);

   // Bucket number width, count width (holds BUCKETS itself), and compare widths.
   localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int CW   = $clog2(BUCKETS + 1);
   localparam int XW   = (BW > BUCKET_W) ? BW : BUCKET_W;
   localparam int CMPW = (CW > BUCKET_W) ? CW : BUCKET_W;

   localparam logic [CW-1:0] BUCKET_LIMIT = CW'(BUCKETS);

   typedef enum logic [1:0] {
      ST_IDLE,    // ready for a transaction
      ST_POP,     // stack top is arriving from the stack memory
      ST_UPDATE   // mask is arriving; modify, write back, deliver result
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;   // depth of the open-bucket stack
   logic [CW-1:0]     used_ff, used_in;     // buckets opened so far
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-transaction context.
   func_type          func_ff, func_in;
   logic              skip_ff, skip_in;     // failed allocate or ignored free
   logic              fresh_ff, fresh_in;   // bucket just opened, mask taken as clear
   logic [BW-1:0]     bucket_ff, bucket_in;
   slot_type          slot_ff, slot_in;

   // Result register.
   status_type        rsp_status_ff, rsp_status_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   slot_type          rsp_slot_ff, rsp_slot_in;

   // Memories and their ports.
   mask_type          mask_mem [BUCKETS];
   logic [BW-1:0]     stack_mem [BUCKETS];
   mask_type          mask_rd_ff;
   logic [BW-1:0]     stk_rd_ff;

   logic              mask_re, mask_we;
   logic [BW-1:0]     mask_raddr, mask_waddr;
   mask_type          mask_wdata;
   logic              stk_re, stk_we;
   logic [BW-1:0]     stk_raddr, stk_waddr;
   logic [BW-1:0]     stk_wdata;

   // Datapath helpers.
   logic [XW-1:0]     fb_wide;
   logic [BW-1:0]     fb_addr;
   logic              fb_open;
   logic [CW-1:0]     count_dec;
   mask_type          cur_mask;
   mask_type          low_bit;
   mask_type          set_mask;
   mask_type          clr_mask;
   logic              cur_full;
   logic              room;
   logic              rsp_go;
   logic [XW-1:0]     bucket_wide;

   assign fb_wide     = XW'(req_free_bucket);
   assign fb_addr     = fb_wide[BW-1:0];
   // Only opened buckets may be freed; anything else is dropped silently.
   assign fb_open     = CMPW'(req_free_bucket) < CMPW'(used_ff);
   assign count_dec   = count_ff - CW'(1);

   // A freshly opened bucket starts empty, whatever its memory word holds.
   assign cur_mask    = fresh_ff ? '0 : mask_rd_ff;
   assign cur_full    = (cur_mask == FULL_MASK);
   assign low_bit     = lowest_clear(cur_mask);
   assign set_mask    = cur_mask | low_bit;
   assign clr_mask    = cur_mask & ~(MASK_ONE << slot_ff);
   assign room        = (count_ff < BUCKET_LIMIT);
   assign bucket_wide = XW'(bucket_ff);

   // A new result may load once the previous one is gone or leaving.
   assign rsp_go      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      func_in       = func_ff;
      skip_in       = skip_ff;
      fresh_in      = fresh_ff;
      bucket_in     = bucket_ff;
      slot_in       = slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_slot_in   = rsp_slot_ff;

      mask_re    = 1'b0;
      mask_raddr = fb_addr;
      mask_we    = 1'b0;
      mask_waddr = bucket_ff;
      mask_wdata = set_mask;
      stk_re     = 1'b0;
      stk_raddr  = count_dec[BW-1:0];
      stk_we     = 1'b0;
      stk_waddr  = count_ff[BW-1:0];
      stk_wdata  = bucket_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = func_type'(req_func);
               slot_in  = req_free_slot;
               fresh_in = 1'b0;
               skip_in  = 1'b0;
               if (func_type'(req_func) == FUNC_ALLOC) begin
                  if (count_ff != '0) begin
                     // Pop: fetch the top entry, then its mask next cycle.
                     stk_re   = 1'b1;
                     count_in = count_dec;
                     state_in = ST_POP;
                  end else if (used_ff < BUCKET_LIMIT) begin
                     // Open the next fresh bucket.
                     bucket_in = used_ff[BW-1:0];
                     used_in   = used_ff + CW'(1);
                     fresh_in  = 1'b1;
                     state_in  = ST_UPDATE;
                  end else begin
                     // All buckets opened and none has room.
                     skip_in  = 1'b1;
                     state_in = ST_UPDATE;
                  end
               end else begin
                  if (fb_open) begin
                     mask_re   = 1'b1;
                     bucket_in = fb_addr;
                  end else begin
                     skip_in = 1'b1;
                  end
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_POP: begin
            bucket_in = stk_rd_ff;
            if (CW'(stk_rd_ff) >= BUCKET_LIMIT) begin
               skip_in = 1'b1;
            end else begin
               mask_re    = 1'b1;
               mask_raddr = stk_rd_ff;
            end
            state_in = ST_UPDATE;
         end

         ST_UPDATE: begin
            // Hold everything, memories included, while the old result waits.
            if (rsp_go) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_bucket_in = '0;
               rsp_slot_in   = '0;
               if (func_ff == FUNC_ALLOC) begin
                  if (skip_ff || cur_full) begin
                     rsp_status_in = STATUS_FAIL;
                  end else begin
                     mask_we       = 1'b1;
                     mask_wdata    = set_mask;
                     rsp_bucket_in = bucket_wide[BUCKET_W-1:0];
                     rsp_slot_in   = onehot_index(low_bit);
                     // Push back unless the bucket just filled up.
                     if (set_mask != FULL_MASK && room) begin
                        stk_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end else if (!skip_ff) begin
                  mask_we    = 1'b1;
                  mask_wdata = clr_mask;
                  // A full bucket regains room: put it back on the stack.
                  if (cur_full && room) begin
                     stk_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      skip_ff       <= skip_in;
      fresh_ff      <= fresh_in;
      bucket_ff     <= bucket_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Occupancy masks: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      if (mask_re) begin
         mask_rd_ff <= mask_mem[mask_raddr];
      end
   end

   // Open-bucket stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stack_mem[stk_raddr];
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_given_bucket = rsp_bucket_ff;
   assign rsp_given_slot   = rsp_slot_ff;

   // Each opened bucket sits on the stack at most once.
   a_count_le_used: assert property (@(posedge clock) disable iff (reset)
      count_ff <= used_ff)
      else $error("open stack deeper than the number of opened buckets");

   a_used_le_limit: assert property (@(posedge clock) disable iff (reset)
      used_ff <= BUCKET_LIMIT)
      else $error("more buckets opened than exist");

   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> used_ff >= $past(used_ff))
      else $error("opened bucket count went down");

   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result loaded outside the update step");

   a_fail_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FAIL |->
         rsp_bucket_ff == '0 && rsp_slot_ff == '0)
      else $error("failed allocate carries a handle");

endmodule

`default_nettype wire

// File: dv/bucket_slot_allocator_tb.sv
// Self-checking testbench for the bucket slot allocator: directed table, random traffic, fill.
`timescale 1ns / 100ps

module bucket_slot_allocator_tb;
   import bsa_pkg::*;

   localparam int NUM_BUCKETS   = 64;
   localparam int RESET_CYCLES  = 6;
   // Settle a little past the longest path through the block (ST_IDLE, ST_POP, ST_UPDATE).
   localparam int SETTLE_CYCLES = 5;
   localparam int IDLE_LIMIT    = 2000;

   // One result transaction as seen on the rsp_ channel.
   typedef struct packed {
      status_type            status;
      logic [BUCKET_W-1:0]   bucket;
      slot_type              slot;
   } grant_type;

   // One row of the directed table; "pinned" rows carry a hand-written grant.
   typedef struct packed {
      func_type              op;
      logic [BUCKET_W-1:0]   bucket;
      slot_type              slot;
      logic                  pinned;
      grant_type             want;
   } stim_row_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_EVERY_THIRD,
      RDY_MOSTLY
   } ready_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic [BUCKET_W-1:0]   req_free_bucket;
   logic [SLOT_W-1:0]     req_free_slot;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_status;
   logic [BUCKET_W-1:0]   rsp_given_bucket;
   logic [SLOT_W-1:0]     rsp_given_slot;

   // Side-band of the request in flight: travels with the payload, held until accepted.
   logic                  row_pinned;
   grant_type             row_want;

   // Shadow allocator state.
   mask_type              occupancy [NUM_BUCKETS];
   logic [BUCKET_W-1:0]   open_buckets [NUM_BUCKETS];
   int                    open_depth;
   int                    buckets_opened;

   grant_type             pending_grants [$];
   logic [11:0]           live_handles [$];
   bit                    failed;
   int                    burst_left;
   int                    idle_cycles;
   ready_mode_type        ready_mode;
   int                    ready_mode_left;
   int                    ready_tick;

   // Directed table: pinned rows are readable straight off the allocation rules.
   stim_row_type directed_rows [18] = '{
      // first allocate opens bucket 0; alloc ignores the free fields
      '{FUNC_ALLOC, 6'd63, 6'd63, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd1}},
      '{FUNC_ALLOC, 6'd21, 6'd42, 1'b1, '{STATUS_DONE, 6'd0, 6'd2}},
      '{FUNC_FREE,  6'd0,  6'd1,  1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      // the hole just made is the lowest clear bit
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd1}},
      // free of a bucket that was never opened
      '{FUNC_FREE,  6'd63, 6'd63, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      // free of a slot that is already clear
      '{FUNC_FREE,  6'd0,  6'd63, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_FREE,  6'd1,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_FREE,  6'd0,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      // double free passes unchecked
      '{FUNC_FREE,  6'd0,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd42, 6'd21, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b1, '{STATUS_DONE, 6'd0, 6'd3}},
      '{FUNC_FREE,  6'd42, 6'd21, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_FREE,  6'd0,  6'd42, 1'b1, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b0, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_FREE,  6'd0,  6'd2,  1'b0, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b0, '{STATUS_DONE, 6'd0, 6'd0}},
      '{FUNC_ALLOC, 6'd0,  6'd0,  1'b0, '{STATUS_DONE, 6'd0, 6'd0}}
   };

   bucket_slot_allocator #(
      .BUCKETS          (NUM_BUCKETS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_free_bucket  (req_free_bucket),
      .req_free_slot    (req_free_slot),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_given_bucket (rsp_given_bucket),
      .rsp_given_slot   (rsp_given_slot)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one accepted request to the shadow state and return the grant it earns.
   function automatic grant_type allocate_or_free(func_type op, logic [BUCKET_W-1:0] fb,
                                                  slot_type fs);
      grant_type g;
      int        b;
      int        s;
      g.status = STATUS_DONE;
      g.bucket = '0;
      g.slot   = '0;
      if (op == FUNC_ALLOC) begin
         // Pop a partly used bucket first; open a fresh one only when none is left.
         if (open_depth > 0) begin
            open_depth--;
            b = open_buckets[open_depth];
         end else if (buckets_opened < NUM_BUCKETS) begin
            b = buckets_opened;
            buckets_opened++;
            occupancy[b] = '0;
         end else begin
            g.status = STATUS_FAIL;
            return g;
         end
         if (occupancy[b] == '1) begin
            g.status = STATUS_FAIL;
            return g;
         end
         s = 0;
         while (occupancy[b][s]) s++;
         occupancy[b][s] = 1'b1;
         // Push back unless the bucket just filled up.
         if (occupancy[b] != '1 && open_depth < NUM_BUCKETS) begin
            open_buckets[open_depth] = b[BUCKET_W-1:0];
            open_depth++;
         end
         g.bucket = b[BUCKET_W-1:0];
         g.slot   = s[SLOT_W-1:0];
         live_handles.push_back({g.bucket, g.slot});
      end else if (int'(fb) < buckets_opened) begin
         // A full bucket regains room, so put it back on the stack first.
         if (occupancy[fb] == '1 && open_depth < NUM_BUCKETS) begin
            open_buckets[open_depth] = fb;
            open_depth++;
         end
         occupancy[fb][fs] = 1'b0;
      end
      return g;
   endfunction

   // Offer one request; burst/gap shaping happens here. Returns at the accepting edge.
   task automatic send_request(func_type op, logic [BUCKET_W-1:0] fb, slot_type fs,
                               logic pinned, grant_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         // Drop valid only for a real gap, so it is never lowered and raised in one step.
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_func        <= op;
      req_free_bucket <= fb;
      req_free_slot   <= fs;
      row_pinned      <= pinned;
      row_want        <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // One random request: allocate, free a live handle, or a stray free of anything.
   task automatic send_random(int alloc_pct);
      int          pick;
      int          idx;
      logic [11:0] h;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
         send_request(FUNC_ALLOC, BUCKET_W'($urandom), SLOT_W'($urandom), 1'b0, '0);
      end else if (pick < 90 && live_handles.size() > 0) begin
         // Claim the handle now so it is not freed twice by accident.
         idx = $urandom_range(0, live_handles.size() - 1);
         h   = live_handles[idx];
         live_handles.delete(idx);
         send_request(FUNC_FREE, h[11:6], h[5:0], 1'b0, '0);
      end else begin
         send_request(FUNC_FREE, BUCKET_W'($urandom), SLOT_W'($urandom), 1'b0, '0);
      end
   endtask

   // Hold the sender until every outstanding grant has come back, then let the pipe settle.
   task automatic wait_all_granted();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Predict on request acceptance; compare on result acceptance.
   always @(posedge clock) begin
      grant_type g;
      grant_type want;
      if (!reset && req_valid && req_ready) begin
         g = allocate_or_free(func_type'(req_func), req_free_bucket, req_free_slot);
         pending_grants.push_back(row_pinned ? row_want : g);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected result transaction: status %0d bucket %0d slot %0d",
                   rsp_status, rsp_given_bucket, rsp_given_slot);
            failed = 1'b1;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_given_bucket !== want.bucket) begin
               $error("rsp_given_bucket: expected %0d, got %0d", want.bucket, rsp_given_bucket);
               failed = 1'b1;
            end
            if (rsp_given_slot !== want.slot) begin
               $error("rsp_given_slot: expected %0d, got %0d", want.slot, rsp_given_slot);
               failed = 1'b1;
            end
         end
      end
   end

   // Receiver backpressure: switch between stall patterns after a random hold.
   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(20, 200);
      end else begin
         ready_mode_left--;
      end
      ready_tick++;
      case (ready_mode)
         RDY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RDY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RDY_EVERY_THIRD: begin
            rsp_ready <= (ready_tick % 3 == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 4) != 0);
         end
      endcase
   end

   // Watchdog: give up after a long stretch with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      // Drive every input known from time zero and hold reset.
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FUNC_ALLOC;
      req_free_bucket <= '0;
      req_free_slot   <= '0;
      row_pinned      <= 1'b0;
      row_want        <= '0;
      failed          = 1'b0;
      burst_left      = 0;
      idle_cycles     = 0;
      ready_mode      = RDY_ALWAYS;
      ready_mode_left = 0;
      ready_tick      = 0;
      foreach (occupancy[i]) occupancy[i] = '0;
      foreach (open_buckets[i]) open_buckets[i] = '0;
      open_depth     = 0;
      buckets_opened = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].bucket, directed_rows[i].slot,
                      directed_rows[i].pinned, directed_rows[i].want);
      end

      // Mixed traffic that spreads allocations over a handful of buckets.
      repeat (150) send_random(55);
      wait_all_granted();

      // Allocate enough to fill the top bucket and at least one more bucket after it.
      repeat (2 * SLOTS) begin
         send_request(FUNC_ALLOC, BUCKET_W'($urandom), SLOT_W'($urandom), 1'b0, '0);
      end
      wait_all_granted();

      // Free-heavy traffic out of full buckets puts them back on the stack.
      repeat (120) send_random(25);
      // Back to mixed traffic on the reshuffled stack.
      repeat (130) send_random(55);
      wait_all_granted();

      if (!failed) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/bsa_pkg.sv
src/bucket_slot_allocator.sv
dv/bucket_slot_allocator_tb.sv
